// File: src/ajs_pkg.sv
// Shared constants and the arctangent table for the arm joint angle solver.
package ajs_pkg;

    // Result angle field width
    localparam int ANGLE_W = 16;

    // Reduced vector components stay below 2^NORM_BITS
    localparam int NORM_BITS = 15;
    localparam int RED_W     = NORM_BITS + 1;

    // Products, cross terms, dot product and squared cross length
    localparam int PROD_W = 2 * RED_W;
    localparam int DOT_W  = PROD_W + 1;
    localparam int SQ_W   = 2 * PROD_W;

    // Integer square root: one result bit per stage
    localparam int ISQRT_STEPS = SQ_W / 2;
    localparam int ROOT_W      = ISQRT_STEPS;

    // Arctangent unit: angles in units of 2^-30 rad
    localparam int CORDIC_STEPS = 30;
    localparam int NORM_MSB     = 29;
    localparam int Z_W          = 33;
    localparam int CX_W         = 34;
    localparam int ATAN_MIN_W   = ROOT_W + 1;

    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [Z_W-1:0] PI_Q30      = 33'sd3373259426;

    // atan(2^-i) in units of 2^-30 rad
    localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
        32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
        32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
        32'd32,        32'd16,        32'd8,         32'd4,         32'd2
    };

endpackage

// File: src/arm_joint_angle_solver.sv
// Top level of the arm joint angle solver: vector setup, reduction, products, root, angles.
//
// Takes one arm pose (shoulder, elbow, wrist) per transfer and returns the shoulder and
// elbow servo angles, rounded to ANGLE_FRAC_BITS fraction bits, plus the side tag and a
// degenerate flag that forces both angles to zero. The datapath is one stall-as-a-whole
// pipeline of 73 register stages; one pose is taken every clock cycle while m_axis_tready
// is high. The 32-stage integer square root of the squared cross product and the two
// 33-stage arctangent units (one for each joint, run side by side) set that depth.
module arm_joint_angle_solver
    import ajs_pkg::*;
#(
    parameter int COORD_WIDTH     = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // shoulder_x, shoulder_y, shoulder_z, elbow_x, elbow_y, elbow_z, wrist_x, wrist_y, wrist_z
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    // arm_side
    input  logic                                     s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // shoulder_angle, elbow_angle
    output logic [2*ANGLE_W-1:0]                     m_axis_tdata,
    // side_tag, degenerate
    output logic [1:0]                               m_axis_tuser
);

    localparam int CW     = COORD_WIDTH;
    localparam int DW     = CW + 1;
    localparam int LW     = $clog2(DW);
    localparam int SHW    = $clog2(DW + 1);
    localparam int ATW    = (DW > ATAN_MIN_W) ? DW : ATAN_MIN_W;
    localparam int RND_SH = 30 - ANGLE_FRAC_BITS;
    localparam logic [Z_W-1:0] RND_HALF = Z_W'(1) << (RND_SH - 1);

    // Side, degenerate flag and the shoulder arctangent operands ride along
    typedef struct packed {
        logic                 side;
        logic                 degen;
        logic signed [DW-1:0] sy;
        logic signed [DW-1:0] sx;
    } carry_t;

    // Cross product z sign: zero, or positive (elbow angle negated)
    typedef struct packed {
        logic zero;
        logic pos;
    } zsign_t;

    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Unpack coordinates and form upper arm and forearm vectors
    logic signed [CW-1:0] p  [9];
    logic signed [DW-1:0] u  [3];
    logic signed [DW-1:0] w  [3];
    carry_t               c1;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            p[k] = s_axis_tdata[k*CW +: CW];
        end
        for (int i = 0; i < 3; i++) begin
            u[i] = DW'(p[3+i]) - DW'(p[i]);
            w[i] = DW'(p[6+i]) - DW'(p[3+i]);
        end
        c1.side  = s_axis_tuser;
        c1.degen = (p[1] == '0) || ((u[0] == '0) && (u[1] == '0)) ||
                   ((w[0] == '0) && (w[1] == '0) && (w[2] == '0));
        c1.sy    = p[1][CW-1] ? -u[1] : u[1];
        c1.sx    = u[0][DW-1] ? -u[0] : u[0];
    end

    logic                 t1_valid_reg;
    carry_t               t1_carry_reg;
    logic signed [DW-1:0] t1_u_reg [3];
    logic signed [DW-1:0] t1_w_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_valid_reg <= 1'b0;
        end else if (en) begin
            t1_valid_reg <= s_axis_tvalid;
            t1_carry_reg <= c1;
            t1_u_reg     <= u;
            t1_w_reg     <= w;
        end
    end

    // Find the right shift that brings each vector below 2^NORM_BITS
    logic [DW-1:0]  um [3];
    logic [DW-1:0]  wm [3];
    logic [DW-1:0]  u_or;
    logic [DW-1:0]  w_or;
    logic [LW-1:0]  u_lead;
    logic [LW-1:0]  w_lead;
    logic [SHW-1:0] u_sh;
    logic [SHW-1:0] w_sh;

    always_comb begin
        u_or   = '0;
        w_or   = '0;
        for (int i = 0; i < 3; i++) begin
            um[i] = t1_u_reg[i][DW-1] ? DW'(-t1_u_reg[i]) : DW'(t1_u_reg[i]);
            wm[i] = t1_w_reg[i][DW-1] ? DW'(-t1_w_reg[i]) : DW'(t1_w_reg[i]);
            u_or  = u_or | um[i];
            w_or  = w_or | wm[i];
        end
        u_lead = '0;
        w_lead = '0;
        for (int b = 0; b < DW; b++) begin
            if (u_or[b]) begin
                u_lead = LW'(b);
            end
            if (w_or[b]) begin
                w_lead = LW'(b);
            end
        end
        u_sh = (int'(u_lead) + 1 > NORM_BITS) ? SHW'(int'(u_lead) + 1 - NORM_BITS) : '0;
        w_sh = (int'(w_lead) + 1 > NORM_BITS) ? SHW'(int'(w_lead) + 1 - NORM_BITS) : '0;
    end

    logic           t2_valid_reg;
    carry_t         t2_carry_reg;
    logic [DW-1:0]  t2_um_reg [3];
    logic [DW-1:0]  t2_wm_reg [3];
    logic [2:0]     t2_un_reg;
    logic [2:0]     t2_wn_reg;
    logic [SHW-1:0] t2_ush_reg;
    logic [SHW-1:0] t2_wsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t2_valid_reg <= 1'b0;
        end else if (en) begin
            t2_valid_reg <= t1_valid_reg;
            t2_carry_reg <= t1_carry_reg;
            t2_um_reg    <= um;
            t2_wm_reg    <= wm;
            for (int i = 0; i < 3; i++) begin
                t2_un_reg[i] <= t1_u_reg[i][DW-1];
                t2_wn_reg[i] <= t1_w_reg[i][DW-1];
            end
            t2_ush_reg   <= u_sh;
            t2_wsh_reg   <= w_sh;
        end
    end

    // Shift magnitudes, restore signs
    logic signed [RED_W-1:0] ur [3];
    logic signed [RED_W-1:0] wr [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ur[i] = $signed({1'b0, NORM_BITS'(t2_um_reg[i] >> t2_ush_reg)});
            wr[i] = $signed({1'b0, NORM_BITS'(t2_wm_reg[i] >> t2_wsh_reg)});
            if (t2_un_reg[i]) begin
                ur[i] = -ur[i];
            end
            if (t2_wn_reg[i]) begin
                wr[i] = -wr[i];
            end
        end
    end

    logic                    t3_valid_reg;
    carry_t                  t3_carry_reg;
    logic signed [RED_W-1:0] t3_u_reg [3];
    logic signed [RED_W-1:0] t3_w_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t3_valid_reg <= 1'b0;
        end else if (en) begin
            t3_valid_reg <= t2_valid_reg;
            t3_carry_reg <= t2_carry_reg;
            t3_u_reg     <= ur;
            t3_w_reg     <= wr;
        end
    end

    // Nine products: ordered as u[i]*w[j] at index 3*i+j
    logic                     t4_valid_reg;
    carry_t                   t4_carry_reg;
    logic signed [PROD_W-1:0] t4_prod_reg [9];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t4_valid_reg <= 1'b0;
        end else if (en) begin
            t4_valid_reg <= t3_valid_reg;
            t4_carry_reg <= t3_carry_reg;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    t4_prod_reg[3*i+j] <= PROD_W'(t3_u_reg[i] * t3_w_reg[j]);
                end
            end
        end
    end

    // Cross product, dot product and the sign of the cross z term
    logic signed [PROD_W-1:0] cr [3];
    logic signed [DOT_W-1:0]  dot;

    always_comb begin
        cr[0] = t4_prod_reg[5] - t4_prod_reg[7];
        cr[1] = t4_prod_reg[6] - t4_prod_reg[2];
        cr[2] = t4_prod_reg[1] - t4_prod_reg[3];
        dot   = DOT_W'(t4_prod_reg[0]) + DOT_W'(t4_prod_reg[4]) + DOT_W'(t4_prod_reg[8]);
    end

    logic                     t5_valid_reg;
    carry_t                   t5_carry_reg;
    logic signed [PROD_W-1:0] t5_cr_reg [3];
    logic signed [DOT_W-1:0]  t5_dot_reg;
    zsign_t                   t5_zs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t5_valid_reg <= 1'b0;
        end else if (en) begin
            t5_valid_reg   <= t4_valid_reg;
            t5_carry_reg   <= t4_carry_reg;
            t5_cr_reg      <= cr;
            t5_dot_reg     <= dot;
            t5_zs_reg.zero <= (cr[2] == '0);
            t5_zs_reg.pos  <= !cr[2][PROD_W-1] && (cr[2] != '0);
        end
    end

    // Square each cross component
    logic                   t6_valid_reg;
    carry_t                 t6_carry_reg;
    logic [SQ_W-1:0]        t6_sq_reg [3];
    logic signed [DOT_W-1:0] t6_dot_reg;
    zsign_t                 t6_zs_reg;
    logic [PROD_W-1:0]      cm [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cm[i] = t5_cr_reg[i][PROD_W-1] ? PROD_W'(-t5_cr_reg[i]) : PROD_W'(t5_cr_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t6_valid_reg <= 1'b0;
        end else if (en) begin
            t6_valid_reg <= t5_valid_reg;
            t6_carry_reg <= t5_carry_reg;
            for (int i = 0; i < 3; i++) begin
                t6_sq_reg[i] <= SQ_W'(cm[i]) * SQ_W'(cm[i]);
            end
            t6_dot_reg   <= t5_dot_reg;
            t6_zs_reg    <= t5_zs_reg;
        end
    end

    // Integer square root pipeline; stage 0 holds the summed squares
    logic                    iq_valid_reg [0:ISQRT_STEPS];
    carry_t                  iq_carry_reg [0:ISQRT_STEPS];
    logic [SQ_W-1:0]         iq_n_reg     [0:ISQRT_STEPS];
    logic [SQ_W-1:0]         iq_r_reg     [0:ISQRT_STEPS];
    logic signed [DOT_W-1:0] iq_dot_reg   [0:ISQRT_STEPS];
    zsign_t                  iq_zs_reg    [0:ISQRT_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iq_valid_reg[0] <= 1'b0;
        end else if (en) begin
            iq_valid_reg[0] <= t6_valid_reg;
            iq_carry_reg[0] <= t6_carry_reg;
            iq_n_reg[0]     <= t6_sq_reg[0] + t6_sq_reg[1] + t6_sq_reg[2];
            iq_r_reg[0]     <= '0;
            iq_dot_reg[0]   <= t6_dot_reg;
            iq_zs_reg[0]    <= t6_zs_reg;
        end
    end

    for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_isqrt
        localparam logic [SQ_W:0] BIT = (SQ_W + 1)'(1) << (SQ_W - 2 - 2 * k);
        logic [SQ_W:0] trial;

        assign trial = {1'b0, iq_r_reg[k]} + BIT;

        // Take one root bit: subtract the trial when it fits
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                iq_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                iq_valid_reg[k+1] <= iq_valid_reg[k];
                if ({1'b0, iq_n_reg[k]} >= trial) begin
                    iq_n_reg[k+1] <= SQ_W'({1'b0, iq_n_reg[k]} - trial);
                    iq_r_reg[k+1] <= (iq_r_reg[k] >> 1) + SQ_W'(BIT);
                end else begin
                    iq_n_reg[k+1] <= iq_n_reg[k];
                    iq_r_reg[k+1] <= iq_r_reg[k] >> 1;
                end
                iq_carry_reg[k+1] <= iq_carry_reg[k];
                iq_dot_reg[k+1]   <= iq_dot_reg[k];
                iq_zs_reg[k+1]    <= iq_zs_reg[k];
            end
        end
    end

    // Arctangent units, one per joint, in lockstep
    carry_t                cq;
    logic signed [ATW-1:0] sh_y;
    logic signed [ATW-1:0] sh_x;
    logic signed [ATW-1:0] el_y;
    logic signed [ATW-1:0] el_x;
    logic                  sh_valid;
    logic                  el_valid;
    logic signed [Z_W-1:0] sh_z;
    logic signed [Z_W-1:0] el_z;
    logic                  sh_degen;
    logic [2:0]            el_tag;

    assign cq   = iq_carry_reg[ISQRT_STEPS];
    assign sh_y = ATW'(cq.sy);
    assign sh_x = ATW'(cq.sx);
    assign el_y = ATW'($signed({1'b0, iq_r_reg[ISQRT_STEPS][ROOT_W-1:0]}));
    assign el_x = ATW'(iq_dot_reg[ISQRT_STEPS]);

    ajs_atan2 #(
        .IW (ATW),
        .TW (1)
    ) u_atan_shoulder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (iq_valid_reg[ISQRT_STEPS]),
        .in_y      (sh_y),
        .in_x      (sh_x),
        .in_tag    (cq.degen),
        .out_valid (sh_valid),
        .out_z     (sh_z),
        .out_tag   (sh_degen)
    );

    ajs_atan2 #(
        .IW (ATW),
        .TW (3)
    ) u_atan_elbow (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (iq_valid_reg[ISQRT_STEPS]),
        .in_y      (el_y),
        .in_x      (el_x),
        .in_tag    ({cq.side, iq_zs_reg[ISQRT_STEPS].zero, iq_zs_reg[ISQRT_STEPS].pos}),
        .out_valid (el_valid),
        .out_z     (el_z),
        .out_tag   (el_tag)
    );

    // Round to nearest, ties away from zero, symmetric in sign
    logic [Z_W-1:0]     sh_mag;
    logic [Z_W-1:0]     el_mag;
    logic [ANGLE_W-1:0] sh_rnd;
    logic [ANGLE_W-1:0] el_rnd;
    logic [ANGLE_W-1:0] sh_ang;
    logic [ANGLE_W-1:0] el_ang;

    always_comb begin
        sh_mag = sh_z[Z_W-1] ? Z_W'(-sh_z) : Z_W'(sh_z);
        el_mag = el_z[Z_W-1] ? Z_W'(-el_z) : Z_W'(el_z);
        sh_rnd = ANGLE_W'((sh_mag + RND_HALF) >> RND_SH);
        el_rnd = ANGLE_W'((el_mag + RND_HALF) >> RND_SH);
        // shoulder angle is the negated arctangent
        sh_ang = (!sh_z[Z_W-1]) ? -sh_rnd : sh_rnd;
        if (el_tag[1]) begin
            el_ang = '0;
        end else begin
            el_ang = (el_tag[0] ^ el_z[Z_W-1]) ? -el_rnd : el_rnd;
        end
        if (sh_degen) begin
            sh_ang = '0;
            el_ang = '0;
        end
    end

    // Output register
    logic                 m_valid_reg;
    logic [2*ANGLE_W-1:0] m_data_reg;
    logic [1:0]           m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= sh_valid && el_valid;
            m_data_reg  <= {el_ang, sh_ang};
            m_user_reg  <= {sh_degen, el_tag[2]};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

// File: src/ajs_atan2.sv
// Pipelined two-argument arctangent: normalize, 30 CORDIC stages, quadrant fix.
module ajs_atan2
    import ajs_pkg::*;
#(
    parameter int IW = 33,
    parameter int TW = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [IW-1:0] in_y,
    input  logic signed [IW-1:0] in_x,
    input  logic [TW-1:0]        in_tag,
    output logic                 out_valid,
    output logic signed [Z_W-1:0] out_z,
    output logic [TW-1:0]        out_tag
);

    localparam int PW = $clog2(IW);
    localparam int WW = IW + NORM_MSB;

    // Quadrant and special-case flags: y zero, x zero, x negative, y negative
    typedef struct packed {
        logic y_zero;
        logic x_zero;
        logic x_neg;
        logic y_neg;
    } flags_t;

    // Magnitudes and leading-one search
    logic [IW-1:0] ax;
    logic [IW-1:0] ay;
    logic [IW-1:0] m_or;
    logic [PW-1:0] lead;

    always_comb begin
        ax   = in_x[IW-1] ? IW'(-in_x) : IW'(in_x);
        ay   = in_y[IW-1] ? IW'(-in_y) : IW'(in_y);
        m_or = ax | ay;
        lead = '0;
        for (int i = 0; i < IW; i++) begin
            if (m_or[i]) begin
                lead = PW'(i);
            end
        end
    end

    logic          s1_valid_reg;
    logic [IW-1:0] s1_ax_reg;
    logic [IW-1:0] s1_ay_reg;
    logic [PW-1:0] s1_lead_reg;
    flags_t        s1_flags_reg;
    logic [TW-1:0] s1_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg        <= in_valid;
            s1_ax_reg           <= ax;
            s1_ay_reg           <= ay;
            s1_lead_reg         <= lead;
            s1_flags_reg.y_zero <= (ay == '0);
            s1_flags_reg.x_zero <= (ax == '0);
            s1_flags_reg.x_neg  <= in_x[IW-1];
            s1_flags_reg.y_neg  <= in_y[IW-1];
            s1_tag_reg          <= in_tag;
        end
    end

    // Scale both so the larger magnitude lies in [2^29, 2^30)
    logic [WW-1:0] wx;
    logic [WW-1:0] wy;

    always_comb begin
        if (int'(s1_lead_reg) >= NORM_MSB) begin
            wx = WW'(s1_ax_reg) >> (int'(s1_lead_reg) - NORM_MSB);
            wy = WW'(s1_ay_reg) >> (int'(s1_lead_reg) - NORM_MSB);
        end else begin
            wx = WW'(s1_ax_reg) << (NORM_MSB - int'(s1_lead_reg));
            wy = WW'(s1_ay_reg) << (NORM_MSB - int'(s1_lead_reg));
        end
    end

    logic                   cv_valid_reg [0:CORDIC_STEPS];
    logic signed [CX_W-1:0] cx_reg       [0:CORDIC_STEPS];
    logic signed [CX_W-1:0] cy_reg       [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]  cz_reg       [0:CORDIC_STEPS];
    flags_t                 cf_reg       [0:CORDIC_STEPS];
    logic [TW-1:0]          ct_reg       [0:CORDIC_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_valid_reg[0] <= 1'b0;
        end else if (en) begin
            cv_valid_reg[0] <= s1_valid_reg;
            cx_reg[0]       <= $signed({4'b0000, wx[NORM_MSB:0]});
            cy_reg[0]       <= $signed({4'b0000, wy[NORM_MSB:0]});
            cz_reg[0]       <= '0;
            cf_reg[0]       <= s1_flags_reg;
            ct_reg[0]       <= s1_tag_reg;
        end
    end

    // One rotation per stage, steering y toward zero
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_valid_reg[i+1] <= 1'b0;
            end else if (en) begin
                cv_valid_reg[i+1] <= cv_valid_reg[i];
                if (!cy_reg[i][CX_W-1]) begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + $signed(Z_W'(ATAN_Q30[i]));
                end else begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - $signed(Z_W'(ATAN_Q30[i]));
                end
                cf_reg[i+1] <= cf_reg[i];
                ct_reg[i+1] <= ct_reg[i];
            end
        end
    end

    // Clamp to the first quadrant, then apply special cases and quadrant
    logic signed [Z_W-1:0] zq;
    logic signed [Z_W-1:0] zf;
    flags_t                fl;

    always_comb begin
        fl = cf_reg[CORDIC_STEPS];
        zq = cz_reg[CORDIC_STEPS];
        if (zq[Z_W-1]) begin
            zq = '0;
        end else if (zq > HALF_PI_Q30) begin
            zq = HALF_PI_Q30;
        end
        if (fl.y_zero) begin
            zq = '0;
        end else if (fl.x_zero) begin
            zq = HALF_PI_Q30;
        end
        zf = fl.x_neg ? (PI_Q30 - zq) : zq;
        if (fl.y_neg) begin
            zf = -zf;
        end
    end

    logic                  o_valid_reg;
    logic signed [Z_W-1:0] o_z_reg;
    logic [TW-1:0]         o_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (en) begin
            o_valid_reg <= cv_valid_reg[CORDIC_STEPS];
            o_z_reg     <= zf;
            o_tag_reg   <= ct_reg[CORDIC_STEPS];
        end
    end

    assign out_valid = o_valid_reg;
    assign out_z     = o_z_reg;
    assign out_tag   = o_tag_reg;

endmodule

// File: src/ajs_checker.sv
// Port-level checks for the arm joint angle solver, bound to the top level.
module ajs_checker #(
    parameter int S_DATA_W = 144,
    parameter int M_DATA_W = 32
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [S_DATA_W-1:0] s_axis_tdata,
    input logic                s_axis_tuser,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]          m_axis_tuser
);

    // A degenerate pose carries zero angles
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
        else $error("degenerate result with nonzero angle");

    // The input side is ready exactly when the output register can move
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // No result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind arm_joint_angle_solver ajs_checker #(
    .S_DATA_W (((9*COORD_WIDTH+7)/8)*8),
    .M_DATA_W (32)
) u_ajs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
